[rtl/fmt_pkg.sv]
`timescale 1ns / 1ps

package fmt_pkg;

   // field widths
   localparam int unsigned FREQ_W   = 21;
   localparam int unsigned KHZ_W    = 17;
   localparam int unsigned VOL_W    = 2;
   localparam int unsigned OFS_W    = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned REQ_DW   = 24;
   localparam int unsigned RSP_DW   = 16;
   localparam int unsigned MUL_W    = 32;

   // intermediate widths, set by the largest 21-bit frequency
   localparam int unsigned X_W      = 14;
   localparam int unsigned SQ_W     = 28;
   localparam int unsigned P_W      = 29;
   localparam int unsigned Q1_W     = 16;
   localparam int unsigned Q2_W     = 16;
   localparam int unsigned Q3_W     = 17;
   localparam int unsigned WORD_W   = 17;

   localparam logic [KHZ_W-1:0] MUTE_KHZ_RESET = 17'd87000;

   // request kinds on req_tuser
   localparam logic REQ_TUNE   = 1'b0;
   localparam logic REQ_VOLUME = 1'b1;

   // card register offsets
   localparam logic [OFS_W-1:0] OFS_VOL_HI  = 4'd0;
   localparam logic [OFS_W-1:0] OFS_VOL_LO  = 4'd2;
   localparam logic [OFS_W-1:0] OFS_TUNE_B8 = 4'd4;
   localparam logic [OFS_W-1:0] OFS_TUNE_HI = 4'd6;
   localparam logic [OFS_W-1:0] OFS_TUNE_LO = 4'd8;

   // polynomial constants
   localparam int unsigned X_DIV     = 160;
   localparam int unsigned Q1_BIAS   = 2500;
   localparam int unsigned Q1_DIV    = 5000;
   localparam int unsigned Q2_BIAS   = 5000;
   localparam int unsigned Q2_DIV    = 10000;
   localparam int unsigned Q3_BIAS   = 10433;
   localparam int unsigned Q3_DIV    = 20866;
   localparam int unsigned TUNE_OFS  = 11505;

   // bit widths of the dividends feeding each constant division
   localparam int unsigned X_N  = FREQ_W;
   localparam int unsigned Q1_N = 28;
   localparam int unsigned Q2_N = 29;
   localparam int unsigned Q3_N = 31;

   // ceiling reciprocals; shift of n + clog2(d) makes floor(a*m >> s) exact for a < 2**n
   localparam int unsigned X_S  = X_N + $clog2(X_DIV);
   localparam int unsigned Q1_S = Q1_N + $clog2(Q1_DIV);
   localparam int unsigned Q2_S = Q2_N + $clog2(Q2_DIV);
   localparam int unsigned Q3_S = Q3_N + $clog2(Q3_DIV);
   localparam logic [63:0] X_M  = ((64'd1 << X_S) + 64'(X_DIV) - 64'd1) / 64'(X_DIV);
   localparam logic [63:0] Q1_M = ((64'd1 << Q1_S) + 64'(Q1_DIV) - 64'd1) / 64'(Q1_DIV);
   localparam logic [63:0] Q2_M = ((64'd1 << Q2_S) + 64'(Q2_DIV) - 64'd1) / 64'(Q2_DIV);
   localparam logic [63:0] Q3_M = ((64'd1 << Q3_S) + 64'(Q3_DIV) - 64'd1) / 64'(Q3_DIV);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VOL_HI,
      ST_VOL_LO,
      ST_X,
      ST_SQ,
      ST_Q1,
      ST_Q3,
      ST_P,
      ST_Q2,
      ST_TUNE_B8,
      ST_TUNE_HI,
      ST_TUNE_LO
   } state_type;

   typedef enum logic [2:0] {
      OP_X,
      OP_SQ,
      OP_Q1,
      OP_Q3,
      OP_P,
      OP_Q2
   } mul_op_type;

   typedef enum logic [2:0] {
      SEL_VOL_HI,
      SEL_VOL_LO,
      SEL_TUNE_B8,
      SEL_TUNE_HI,
      SEL_TUNE_LO
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_op_type  op;
      logic        out_load;
      out_sel_type sel;
      logic        out_last;
   } fmt_cmd_type;

   typedef struct packed {
      logic retune;
      logic out_free;
   } fmt_status_type;

endpackage

[rtl/fmt_ctrl.sv]
`timescale 1ns / 1ps

module fmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tuser,
   output logic                    req_tready,
   input  fmt_pkg::fmt_status_type status,
   output fmt_pkg::fmt_cmd_type    cmd
);
   import fmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.capture  = 1'b0;
      cmd.mul_en   = 1'b0;
      cmd.op       = OP_X;
      cmd.out_load = 1'b0;
      cmd.sel      = SEL_VOL_HI;
      cmd.out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_tuser == REQ_VOLUME) ? ST_VOL_HI : ST_X;
            end
         end
         ST_VOL_HI: begin
            cmd.sel = SEL_VOL_HI;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_VOL_LO;
            end
         end
         ST_VOL_LO: begin
            cmd.sel      = SEL_VOL_LO;
            cmd.out_last = !status.retune;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.retune ? ST_X : ST_IDLE;
            end
         end
         ST_X: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_X;
            state_in   = ST_SQ;
         end
         ST_SQ: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_SQ;
            state_in   = ST_Q1;
         end
         ST_Q1: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_Q1;
            state_in   = ST_Q3;
         end
         ST_Q3: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_Q3;
            state_in   = ST_P;
         end
         ST_P: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_P;
            state_in   = ST_Q2;
         end
         ST_Q2: begin
            cmd.mul_en = 1'b1;
            cmd.op     = OP_Q2;
            state_in   = ST_TUNE_B8;
         end
         ST_TUNE_B8: begin
            cmd.sel = SEL_TUNE_B8;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_TUNE_HI;
            end
         end
         ST_TUNE_HI: begin
            cmd.sel = SEL_TUNE_HI;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_TUNE_LO;
            end
         end
         ST_TUNE_LO: begin
            cmd.sel      = SEL_TUNE_LO;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/fmt_datapath.sv]
`timescale 1ns / 1ps

module fmt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [fmt_pkg::REQ_DW-1:0]           req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 csr_wr_en,
   input  logic [fmt_pkg::KHZ_W-1:0]            csr_wr_data,
   input  fmt_pkg::fmt_cmd_type                 cmd,
   output fmt_pkg::fmt_status_type              status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fmt_pkg::RSP_DW-1:0]           rsp_tdata,
   output logic                                 rsp_tlast
);
   import fmt_pkg::*;

   logic [KHZ_W-1:0]  mute_khz_ff;
   logic              muted_ff;
   logic              retune_ff;
   logic [FREQ_W-1:0] stored_freq_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [VOL_W-1:0]  vol_ff;

   logic [X_W-1:0]    x_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [Q1_W-1:0]   q1_ff;
   logic [Q3_W-1:0]   q3_ff;
   logic [P_W-1:0]    p_ff;
   logic [Q2_W-1:0]   q2_ff;

   logic              rsp_valid_ff;
   logic [OFS_W-1:0]  ofs_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   logic [FREQ_W-1:0] in_freq;
   logic              in_mute;
   logic [VOL_W-1:0]  in_vol;
   logic [VOL_W-1:0]  vol_eff;
   logic              retune_c;

   logic [MUL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   logic [63:0]       product;
   logic [WORD_W-1:0] word;
   logic [OFS_W-1:0]  ofs_c;
   logic [BYTE_W-1:0] data_c;

   assign in_freq  = req_tdata[FREQ_W-1:0];
   assign in_mute  = req_tdata[FREQ_W];
   assign in_vol   = req_tdata[FREQ_W+VOL_W:FREQ_W+1];
   assign vol_eff  = in_mute ? '0 : in_vol;
   // mute state flips whenever the effective volume crosses zero
   assign retune_c = (vol_eff == '0) != muted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_khz_ff    <= MUTE_KHZ_RESET;
         muted_ff       <= 1'b0;
         retune_ff      <= 1'b0;
         stored_freq_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mute_khz_ff <= csr_wr_data;
         end
         if (cmd.capture && req_tuser == REQ_TUNE) begin
            stored_freq_ff <= in_freq;
         end
         if (cmd.capture && req_tuser == REQ_VOLUME) begin
            retune_ff <= retune_c;
            if (retune_c) begin
               muted_ff <= !muted_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (req_tuser == REQ_TUNE) begin
            freq_ff <= in_freq;
         end else begin
            vol_ff  <= vol_eff;
            freq_ff <= muted_ff ? stored_freq_ff : {mute_khz_ff, 4'd0};
         end
      end
   end

   // one shared multiplier, stepped through the polynomial by the controller
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_X: begin
            mul_a = MUL_W'(freq_ff);
            mul_b = X_M[MUL_W-1:0];
         end
         OP_SQ: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(x_ff);
         end
         OP_Q1: begin
            mul_a = MUL_W'(sq_ff) + MUL_W'(Q1_BIAS);
            mul_b = Q1_M[MUL_W-1:0];
         end
         OP_Q3: begin
            mul_a = (MUL_W'(sq_ff) << 3) + (MUL_W'(sq_ff) << 1) + MUL_W'(Q3_BIAS);
            mul_b = Q3_M[MUL_W-1:0];
         end
         OP_P: begin
            mul_a = MUL_W'(q1_ff);
            mul_b = MUL_W'(x_ff);
         end
         OP_Q2: begin
            mul_a = MUL_W'(p_ff) + MUL_W'(Q2_BIAS);
            mul_b = Q2_M[MUL_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.op)
            OP_X:    x_ff  <= X_W'(product >> X_S);
            OP_SQ:   sq_ff <= SQ_W'(product);
            OP_Q1:   q1_ff <= Q1_W'(product >> Q1_S);
            OP_Q3:   q3_ff <= Q3_W'(product >> Q3_S);
            OP_P:    p_ff  <= P_W'(product);
            OP_Q2:   q2_ff <= Q2_W'(product >> Q2_S);
            default: x_ff  <= x_ff;
         endcase
      end
   end

   // only the low 17 bits of the modulo-2^32 word reach the card
   assign word = WORD_W'(q2_ff) - q3_ff + {1'b0, x_ff, 2'b00} - WORD_W'(TUNE_OFS);

   always_comb begin
      ofs_c  = OFS_VOL_HI;
      data_c = '0;
      case (cmd.sel)
         SEL_VOL_HI: begin
            ofs_c  = OFS_VOL_HI;
            data_c = {7'd0, vol_ff[1]};
         end
         SEL_VOL_LO: begin
            ofs_c  = OFS_VOL_LO;
            data_c = {7'd0, vol_ff[0]};
         end
         SEL_TUNE_B8: begin
            ofs_c  = OFS_TUNE_B8;
            data_c = {7'd0, word[8]};
         end
         SEL_TUNE_HI: begin
            ofs_c  = OFS_TUNE_HI;
            data_c = word[16:9];
         end
         SEL_TUNE_LO: begin
            ofs_c  = OFS_TUNE_LO;
            data_c = word[7:0];
         end
         default: begin
            ofs_c  = OFS_VOL_HI;
            data_c = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ofs_ff  <= ofs_c;
         data_ff <= data_c;
         last_ff <= cmd.out_last;
      end
   end

   assign status.retune   = retune_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, data_ff, ofs_ff};
   assign rsp_tlast  = last_ff;

endmodule

[rtl/fm_tuner_word_and_mute_control.sv]
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: tune_freq, mute, volume; tuser: req_type
// rsp       out        rsp_tvalid/rsp_tready  tdata: port_offset, port_data; tlast: last_write
// csr       in         csr_wr_en              csr_wr_data: mute_freq_khz
//
// one request at a time; a tune makes six passes through the shared multiplier, then three writes.
// a volume request writes the volume high and low bits, then also retunes when it enters or leaves mute.
// reset is synchronous: mute state and stored frequency clear, mute frequency is 87000 kHz.
// a stalled rsp side holds the sequencer at the next write; results are never dropped.

module fm_tuner_word_and_mute_control (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fmt_pkg::REQ_DW-1:0]     req_tdata,   // tune_freq[20:0], mute[21], volume[23:22]
   input  logic                           req_tuser,   // req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fmt_pkg::RSP_DW-1:0]     rsp_tdata,   // port_offset[3:0], port_data[11:4]
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [fmt_pkg::KHZ_W-1:0]      csr_wr_data
);
   import fmt_pkg::*;

   fmt_cmd_type    cmd;
   fmt_status_type status;

   fmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fmt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[rtl/fmt_checker.sv]
`timescale 1ns / 1ps

module fmt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [fmt_pkg::RSP_DW-1:0] rsp_tdata,
   input logic                       rsp_tlast
);
   import fmt_pkg::*;

   logic [OFS_W-1:0] ofs;
   assign ofs = rsp_tdata[OFS_W-1:0];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_offset_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ofs == OFS_VOL_HI || ofs == OFS_VOL_LO || ofs == OFS_TUNE_B8 ||
                      ofs == OFS_TUNE_HI || ofs == OFS_TUNE_LO))
      else $error("unknown port offset");

   a_one_bit_regs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (ofs == OFS_VOL_HI || ofs == OFS_TUNE_B8)
      |-> rsp_tdata[11:5] == '0 && !rsp_tlast)
      else $error("single-bit register write malformed");

   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (ofs == OFS_TUNE_LO)) || ofs == OFS_VOL_LO)
      else $error("last marker on wrong write");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp transaction changed");

endmodule

bind fm_tuner_word_and_mute_control fmt_checker u_fmt_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import fmt_pkg::*;

   typedef struct {
      logic              kind;
      logic [FREQ_W-1:0] freq;
      logic              mute;
      logic [VOL_W-1:0]  vol;
   } tuner_req_type;

   typedef struct {
      logic [OFS_W-1:0]  ofs;
      logic [BYTE_W-1:0] data;
      logic              last;
   } port_write_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;   // tune_freq[20:0], mute[21], volume[23:22]
   logic              req_tuser;   // req_type
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;   // port_offset[3:0], port_data[11:4]
   logic              rsp_tlast;   // last_write
   logic              csr_wr_en;
   logic [KHZ_W-1:0]  csr_wr_data;

   tuner_req_type  pending_reqs[$];
   port_write_type port_writes_due[$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   // predictor state
   logic              tuner_muted = 1'b0;
   logic [FREQ_W-1:0] tuned_freq = '0;
   logic [KHZ_W-1:0]  mute_khz = MUTE_KHZ_RESET;

   fm_tuner_word_and_mute_control dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   // cubic tuning word, all steps modulo 2**32
   function automatic logic [31:0] tuning_word(logic [FREQ_W-1:0] freq);
      logic [31:0] x;
      logic [31:0] w;
      x = 32'(freq) / 32'd160;
      w = (x * x + 32'd2500) / 32'd5000;
      w = (w * x + 32'd5000) / 32'd10000;
      w = w - (32'd10 * x * x + 32'd10433) / 32'd20866;
      w = w + 32'd4 * x - 32'd11505;
      return w;
   endfunction

   task automatic push_write(logic [OFS_W-1:0] ofs, logic [BYTE_W-1:0] data, logic last);
      port_write_type pw;
      pw.ofs = ofs;
      pw.data = data;
      pw.last = last;
      port_writes_due.push_back(pw);
   endtask

   task automatic queue_tune_writes(logic [FREQ_W-1:0] freq);
      logic [31:0] w;
      w = tuning_word(freq);
      push_write(OFS_TUNE_B8, {7'b0, w[8]}, 1'b0);
      push_write(OFS_TUNE_HI, w[16:9], 1'b0);
      push_write(OFS_TUNE_LO, w[7:0], 1'b1);
   endtask

   task automatic predict_port_writes(tuner_req_type r);
      logic [VOL_W-1:0] level;
      logic             entering;
      logic             leaving;
      if (r.kind == REQ_TUNE) begin
         tuned_freq = r.freq;
         queue_tune_writes(r.freq);
      end else begin
         level = r.mute ? '0 : r.vol;
         entering = (level == 0) && !tuner_muted;
         leaving = (level != 0) && tuner_muted;
         push_write(OFS_VOL_HI, {7'b0, level[1]}, 1'b0);
         push_write(OFS_VOL_LO, {7'b0, level[0]}, !(entering || leaving));
         if (entering) begin
            tuner_muted = 1'b1;
            queue_tune_writes({mute_khz, 4'b0});
         end else if (leaving) begin
            tuner_muted = 1'b0;
            queue_tune_writes(tuned_freq);
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      tuner_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tdata <= {nxt.vol, nxt.mute, nxt.freq};
            req_tuser <= nxt.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor: results first, since a write seen at the acceptance edge is from an older request
   always @(posedge clock) begin : monitor
      port_write_type want;
      tuner_req_type  got_req;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (port_writes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp transaction ofs=%0d data=%0h",
                                         rsp_tdata[3:0], rsp_tdata[11:4]));
            end else begin
               want = port_writes_due.pop_front();
               if (rsp_tdata[3:0] !== want.ofs)
                  report_mismatch($sformatf("port_offset got %0d want %0d",
                                            rsp_tdata[3:0], want.ofs));
               if (rsp_tdata[11:4] !== want.data)
                  report_mismatch($sformatf("port_data got %0h want %0h (ofs %0d)",
                                            rsp_tdata[11:4], want.data, want.ofs));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last_write got %b want %b (ofs %0d)",
                                            rsp_tlast, want.last, want.ofs));
               if (rsp_tdata[15:12] !== 4'b0)
                  report_mismatch($sformatf("rsp_tdata pad bits %b", rsp_tdata[15:12]));
            end
         end
         if (req_tvalid && req_tready) begin
            got_req.kind = req_tuser;
            got_req.freq = req_tdata[20:0];
            got_req.mute = req_tdata[21];
            got_req.vol = req_tdata[23:22];
            predict_port_writes(got_req);
         end
      end
   end

   task automatic add_req(logic kind, logic [FREQ_W-1:0] freq, logic mute,
                          logic [VOL_W-1:0] vol);
      tuner_req_type r;
      r.kind = kind;
      r.freq = freq;
      r.mute = mute;
      r.vol = vol;
      pending_reqs.push_back(r);
   endtask

   task automatic add_random_reqs(int count);
      logic [FREQ_W-1:0] f;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3, 0))
            0: f = FREQ_W'($urandom);
            1: f = FREQ_W'($urandom_range(108000 * 16, 87000 * 16));
            2: f = FREQ_W'($urandom_range(2000, 0));
            default: f = FREQ_W'($urandom_range(21'h1fffff, 21'h1f0000));
         endcase
         add_req($urandom_range(1, 0) ? REQ_VOLUME : REQ_TUNE, f,
                 $urandom_range(3, 0) == 0, VOL_W'($urandom_range(3, 0)));
      end
   endtask

   // wait until every request is accepted and every write has come back
   task automatic drain;
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || port_writes_due.size() != 0);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_mute_khz(logic [KHZ_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mute_khz = v;
   endtask

   task automatic run_phase(logic [KHZ_W-1:0] khz, int send_pct, int recv_pct, int count);
      write_mute_khz(khz);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      add_random_reqs(count);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 20;
      recv_idle_pct = 63;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // mute and unmute before any tune, then tune while muted
      add_req(REQ_VOLUME, '0, 1'b0, 2'd0);
      add_req(REQ_VOLUME, '0, 1'b0, 2'd0);
      add_req(REQ_VOLUME, '0, 1'b0, 2'd3);
      add_req(REQ_VOLUME, '0, 1'b1, 2'd3);
      add_req(REQ_TUNE, 21'h1fffff, 1'b1, 2'd3);
      add_req(REQ_VOLUME, '0, 1'b0, 2'd1);
      add_req(REQ_VOLUME, '0, 1'b0, 2'd2);
      add_req(REQ_TUNE, 21'd0, 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'd159, 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'd160, 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'(87000 * 16), 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'(108000 * 16), 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'h155555, 1'b0, 2'd0);
      add_req(REQ_TUNE, 21'h0aaaaa, 1'b1, 2'd3);
      add_req(REQ_VOLUME, 21'h1fffff, 1'b0, 2'd3);
      add_req(REQ_VOLUME, '0, 1'b1, 2'd0);
      add_req(REQ_VOLUME, '0, 1'b1, 2'd2);
      add_req(REQ_VOLUME, '0, 1'b0, 2'd2);
      drain();

      run_phase('0, 20, 63, 73);
      run_phase('1, 63, 20, 73);
      run_phase(17'd108000, 0, 0, 73);
      run_phase(KHZ_W'($urandom_range(108000, 87000)), 0, 0, 73);

      if (port_writes_due.size() != 0)
         report_mismatch($sformatf("%0d writes never arrived", port_writes_due.size()));
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
